FILE: hdl/sliding_mode_position_controller_macros.svh
// ----------------------------------------------------------------------------
// Sliding-mode position controller assertion macros
// Implication and next-cycle implication checks, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MODE_POSITION_CONTROLLER_MACROS_SVH
`define SLIDING_MODE_POSITION_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
`define SMPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define SMPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SMPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/smpc_pkg.sv
// ----------------------------------------------------------------------------
// Sliding-mode position controller package
// Widths, payload and command types, register indexes and reset values.
// ----------------------------------------------------------------------------
package smpc_pkg;

    localparam int GAIN_FRAC_BITS = 16;

    localparam int GAIN_W   = 32;
    localparam int STEP_W   = 16;
    localparam int LIMIT_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int TICK_W   = 32;
    localparam int DUTY_W   = 16;
    localparam int MOTION_W = 2;
    localparam int CFG_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam int POS_W  = 32;
    localparam int ERR_W  = POS_W + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int MAG_W  = ERR_W;
    localparam int NUM_W  = MAG_W + GAIN_FRAC_BITS;
    localparam int D_W    = NUM_W + 1;
    localparam int REM_W  = TICK_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam int OPB_W   = 64;
    localparam int HALF_W  = OPB_W / 2;
    localparam int CHUNK_W = HALF_W + 1;
    localparam int PROD_W  = GAIN_W + CHUNK_W;
    localparam int ACC_W   = GAIN_W + OPB_W;
    localparam int OUT_SHIFT = 2 * GAIN_FRAC_BITS;
    localparam int Q_W     = ACC_W - OUT_SHIFT;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SURFACE_SLOPE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SWITCH_GAIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SWITCH_SCALE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT_STEP = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 3'd6;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST     = 32'sd32768;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST    = 32'sd0;
    localparam logic signed [GAIN_W-1:0] SURFACE_SLOPE_RST = 32'sd98304;
    localparam logic signed [GAIN_W-1:0] SWITCH_GAIN_RST   = 32'sd655360;
    localparam logic signed [GAIN_W-1:0] SWITCH_SCALE_RST  = -32'sd328;
    localparam logic [STEP_W-1:0]        SETPOINT_STEP_RST = 16'd100;
    localparam logic [LIMIT_W-1:0]       OUTPUT_LIMIT_RST  = 16'd500;

    localparam logic [MOTION_W-1:0] MOTION_HOLD    = 2'd0;
    localparam logic [MOTION_W-1:0] MOTION_FORWARD = 2'd1;
    localparam logic [MOTION_W-1:0] MOTION_REVERSE = 2'd2;

    typedef enum logic [2:0] {
        OP_SLOPE_E,
        OP_ONE_D,
        OP_PROP_E,
        OP_DERIV_D,
        OP_SWITCH
    } op_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] encoder_count;
        logic [TICK_W-1:0]         tick_ms;
        logic                      step_up;
        logic                      step_down;
    } in_t;

    typedef struct packed {
        logic [DUTY_W-1:0]   drive_duty;
        logic [MOTION_W-1:0] motion;
    } out_t;

    typedef struct packed {
        logic load;
        logic calc_e;
        logic calc_diff;
        logic div_init;
        logic div_step;
        logic d_take;
        logic acc_clr;
        logic mul_go;
        op_t  mul_op;
        logic mul_hi;
        logic sg_take;
        logic abs_take;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

FILE: hdl/smpc_dpath.sv
// ----------------------------------------------------------------------------
// Sliding-mode position controller datapath
// Settings, state, radix-2 divider, shared multiply-accumulate and result.
// ----------------------------------------------------------------------------
module smpc_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [smpc_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [smpc_pkg::CFG_W-1:0]        cfg_data,
    input  smpc_pkg::in_t                     in_data,
    input  smpc_pkg::cmd_t                    cmd,
    output smpc_pkg::status_t                 status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output smpc_pkg::out_t                    m_data
);

    localparam int GAIN_W  = smpc_pkg::GAIN_W;
    localparam int STEP_W  = smpc_pkg::STEP_W;
    localparam int LIMIT_W = smpc_pkg::LIMIT_W;
    localparam int POS_W   = smpc_pkg::POS_W;
    localparam int ERR_W   = smpc_pkg::ERR_W;
    localparam int DIFF_W  = smpc_pkg::DIFF_W;
    localparam int MAG_W   = smpc_pkg::MAG_W;
    localparam int NUM_W   = smpc_pkg::NUM_W;
    localparam int D_W     = smpc_pkg::D_W;
    localparam int REM_W   = smpc_pkg::REM_W;
    localparam int OPB_W   = smpc_pkg::OPB_W;
    localparam int HALF_W  = smpc_pkg::HALF_W;
    localparam int CHUNK_W = smpc_pkg::CHUNK_W;
    localparam int PROD_W  = smpc_pkg::PROD_W;
    localparam int ACC_W   = smpc_pkg::ACC_W;
    localparam int Q_W     = smpc_pkg::Q_W;
    localparam int FRAC    = smpc_pkg::GAIN_FRAC_BITS;
    localparam int SUM_W   = POS_W + 1;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-(64'sd1 <<< (POS_W - 1)));

    logic signed [GAIN_W-1:0]  prop_gain_reg;
    logic signed [GAIN_W-1:0]  deriv_gain_reg;
    logic signed [GAIN_W-1:0]  surface_slope_reg;
    logic signed [GAIN_W-1:0]  switch_gain_reg;
    logic signed [GAIN_W-1:0]  switch_scale_reg;
    logic [STEP_W-1:0]         setpoint_step_reg;
    logic [LIMIT_W-1:0]        output_limit_reg;

    logic signed [POS_W-1:0]   target_reg;
    logic signed [POS_W-1:0]   target_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic [smpc_pkg::TICK_W-1:0] prev_tick_reg;

    logic signed [smpc_pkg::COUNT_W-1:0] count_reg;
    logic [smpc_pkg::TICK_W-1:0] tick_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [smpc_pkg::TICK_W-1:0] dt_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [REM_W-1:0]          rem_next;
    logic [NUM_W-1:0]          quo_reg;
    logic [NUM_W-1:0]          quo_next;
    logic signed [D_W-1:0]     d_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_hi_reg;
    logic                      prod_vld_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      sg_neg_reg;
    logic                      sg_nz_reg;
    logic [ACC_W-1:0]          mag_reg;
    logic                      m_valid_reg;
    smpc_pkg::out_t            out_reg;

    logic signed [SUM_W-1:0]   tgt_inc;
    logic signed [SUM_W-1:0]   tgt_dec;
    logic signed [SUM_W-1:0]   step_ext;
    logic signed [DIFF_W-1:0]  diff_abs;
    logic [REM_W-1:0]          rem_sh;
    logic [REM_W-1:0]          dt_ext;
    logic                      rem_ge;
    logic signed [GAIN_W-1:0]  mul_gain;
    logic signed [OPB_W-1:0]   mul_opb;
    logic signed [OPB_W-1:0]   scale_ext;
    logic signed [CHUNK_W-1:0] mul_chunk;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [ACC_W-1:0]   acc_add;
    logic [Q_W-1:0]            q_val;
    logic                      q_over;
    logic [smpc_pkg::DUTY_W-1:0] duty_val;

    // setpoint step with saturation
    always_comb begin
        step_ext = signed'(SUM_W'(setpoint_step_reg));
        tgt_inc  = SUM_W'(target_reg) + step_ext;
        tgt_dec  = SUM_W'(target_reg) - step_ext;
        if (in_data.step_up) begin
            target_next = (tgt_inc > POS_MAX) ? POS_W'(POS_MAX) : tgt_inc[POS_W-1:0];
        end else if (in_data.step_down) begin
            target_next = (tgt_dec < POS_MIN) ? POS_W'(POS_MIN) : tgt_dec[POS_W-1:0];
        end else begin
            target_next = target_reg;
        end
    end

    // restoring divider step
    always_comb begin
        diff_abs = diff_reg[DIFF_W-1] ? -diff_reg : diff_reg;
        rem_sh   = {rem_reg[REM_W-2:0], quo_reg[NUM_W-1]};
        dt_ext   = REM_W'(dt_reg);
        rem_ge   = (rem_sh >= dt_ext);
        rem_next = rem_ge ? (rem_sh - dt_ext) : rem_sh;
        quo_next = {quo_reg[NUM_W-2:0], rem_ge};
    end

    // multiplier operand select
    always_comb begin
        scale_ext = OPB_W'(switch_scale_reg);
        unique case (cmd.mul_op)
            smpc_pkg::OP_SLOPE_E: begin
                mul_gain = surface_slope_reg;
                mul_opb  = OPB_W'(e_reg);
            end
            smpc_pkg::OP_ONE_D: begin
                mul_gain = GAIN_W'(1);
                mul_opb  = OPB_W'(d_reg);
            end
            smpc_pkg::OP_PROP_E: begin
                mul_gain = prop_gain_reg;
                mul_opb  = OPB_W'(e_reg) <<< FRAC;
            end
            smpc_pkg::OP_DERIV_D: begin
                mul_gain = deriv_gain_reg;
                mul_opb  = OPB_W'(d_reg);
            end
            smpc_pkg::OP_SWITCH: begin
                mul_gain = switch_gain_reg;
                if (!sg_nz_reg) begin
                    mul_opb = '0;
                end else if (sg_neg_reg) begin
                    mul_opb = -scale_ext;
                end else begin
                    mul_opb = scale_ext;
                end
            end
            default: begin
                mul_gain = '0;
                mul_opb  = '0;
            end
        endcase
        if (cmd.mul_hi) begin
            mul_chunk = {mul_opb[OPB_W-1], mul_opb[OPB_W-1:HALF_W]};
        end else begin
            mul_chunk = {1'b0, mul_opb[HALF_W-1:0]};
        end
        prod_full = PROD_W'(mul_gain) * PROD_W'(mul_chunk);
    end

    always_comb begin
        acc_add  = prod_hi_reg ? (ACC_W'(prod_reg) <<< HALF_W) : ACC_W'(prod_reg);
        acc_next = acc_reg + acc_add;
    end

    // clamp and direction
    always_comb begin
        q_val    = mag_reg[ACC_W-1:smpc_pkg::OUT_SHIFT];
        q_over   = (|q_val[Q_W-1:LIMIT_W]) || (q_val[LIMIT_W-1:0] > output_limit_reg);
        duty_val = q_over ? output_limit_reg : q_val[LIMIT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= smpc_pkg::PROP_GAIN_RST;
            deriv_gain_reg    <= smpc_pkg::DERIV_GAIN_RST;
            surface_slope_reg <= smpc_pkg::SURFACE_SLOPE_RST;
            switch_gain_reg   <= smpc_pkg::SWITCH_GAIN_RST;
            switch_scale_reg  <= smpc_pkg::SWITCH_SCALE_RST;
            setpoint_step_reg <= smpc_pkg::SETPOINT_STEP_RST;
            output_limit_reg  <= smpc_pkg::OUTPUT_LIMIT_RST;
            target_reg        <= '0;
            prev_err_reg      <= '0;
            prev_tick_reg     <= '0;
            prod_vld_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    smpc_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                    smpc_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                    smpc_pkg::REG_SURFACE_SLOPE: surface_slope_reg <= cfg_data;
                    smpc_pkg::REG_SWITCH_GAIN:   switch_gain_reg   <= cfg_data;
                    smpc_pkg::REG_SWITCH_SCALE:  switch_scale_reg  <= cfg_data;
                    smpc_pkg::REG_SETPOINT_STEP: setpoint_step_reg <= cfg_data[STEP_W-1:0];
                    smpc_pkg::REG_OUTPUT_LIMIT:  output_limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.load) begin
                target_reg <= target_next;
            end
            if (cmd.calc_diff) begin
                prev_err_reg  <= e_reg;
                prev_tick_reg <= tick_reg;
            end
            prod_vld_reg <= cmd.mul_go;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            count_reg <= in_data.encoder_count;
            tick_reg  <= in_data.tick_ms;
        end
        if (cmd.calc_e) begin
            e_reg <= ERR_W'(target_reg) - ERR_W'(count_reg);
        end
        if (cmd.calc_diff) begin
            diff_reg <= DIFF_W'(e_reg) - DIFF_W'(prev_err_reg);
            dt_reg   <= tick_reg - prev_tick_reg;
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= {diff_abs[MAG_W-1:0], {FRAC{1'b0}}};
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.d_take) begin
            if (dt_reg == '0) begin
                d_reg <= '0;
            end else if (diff_reg[DIFF_W-1]) begin
                d_reg <= -signed'({1'b0, quo_reg});
            end else begin
                d_reg <= signed'({1'b0, quo_reg});
            end
        end
        if (cmd.mul_go) begin
            prod_reg    <= prod_full;
            prod_hi_reg <= cmd.mul_hi;
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_next;
        end
        if (cmd.sg_take) begin
            sg_neg_reg <= acc_reg[ACC_W-1];
            sg_nz_reg  <= |acc_reg;
        end
        if (cmd.abs_take) begin
            mag_reg <= acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        end
        if (cmd.emit) begin
            if (e_reg > 0) begin
                out_reg.motion     <= smpc_pkg::MOTION_FORWARD;
                out_reg.drive_duty <= duty_val;
            end else if (e_reg < 0) begin
                out_reg.motion     <= smpc_pkg::MOTION_REVERSE;
                out_reg.drive_duty <= duty_val;
            end else begin
                out_reg.motion     <= smpc_pkg::MOTION_HOLD;
                out_reg.drive_duty <= '0;
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

endmodule

FILE: hdl/smpc_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding-mode position controller sequencer
// Steps one request through error, divide, multiply-accumulate and result.
// ----------------------------------------------------------------------------
module smpc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  smpc_pkg::status_t status,
    output smpc_pkg::cmd_t    cmd
);

    localparam int DIV_CNT_W = smpc_pkg::DIV_CNT_W;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(smpc_pkg::NUM_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC_E,
        ST_CALC_DIFF,
        ST_DIV_INIT,
        ST_DIV,
        ST_D_TAKE,
        ST_MUL,
        ST_DRAIN,
        ST_SIGN,
        ST_ABS,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    smpc_pkg::op_t          op_reg;
    logic                   hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= smpc_pkg::OP_SLOPE_E;
            hi_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CALC_E;
                    end
                end
                ST_CALC_E:    state_reg <= ST_CALC_DIFF;
                ST_CALC_DIFF: state_reg <= ST_DIV_INIT;
                ST_DIV_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_D_TAKE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_D_TAKE: begin
                    op_reg    <= smpc_pkg::OP_SLOPE_E;
                    hi_reg    <= 1'b0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (!hi_reg) begin
                        hi_reg <= 1'b1;
                    end else begin
                        hi_reg <= 1'b0;
                        unique case (op_reg)
                            smpc_pkg::OP_SLOPE_E: op_reg <= smpc_pkg::OP_ONE_D;
                            smpc_pkg::OP_PROP_E:  op_reg <= smpc_pkg::OP_DERIV_D;
                            smpc_pkg::OP_DERIV_D: op_reg <= smpc_pkg::OP_SWITCH;
                            default:              state_reg <= ST_DRAIN;
                        endcase
                    end
                end
                ST_DRAIN: begin
                    state_reg <= (op_reg == smpc_pkg::OP_ONE_D) ? ST_SIGN : ST_ABS;
                end
                ST_SIGN: begin
                    op_reg    <= smpc_pkg::OP_PROP_E;
                    state_reg <= ST_MUL;
                end
                ST_ABS: state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.mul_op = op_reg;
        cmd.mul_hi = hi_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CALC_E:    cmd.calc_e    = 1'b1;
            ST_CALC_DIFF: cmd.calc_diff = 1'b1;
            ST_DIV_INIT:  cmd.div_init  = 1'b1;
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_D_TAKE: begin
                cmd.d_take  = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_MUL:       cmd.mul_go    = 1'b1;
            ST_SIGN: begin
                cmd.sg_take = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_ABS:       cmd.abs_take  = 1'b1;
            ST_EMIT:      cmd.emit      = status.out_free;
            default: begin
            end
        endcase
    end

endmodule

FILE: hdl/sliding_mode_position_controller.sv
// ----------------------------------------------------------------------------
// Sliding-mode position controller
// One request at a time: s_ready stays low until the result is emitted, and
// emit waits for the previous result to be taken. 49-step divider, ten 32x33
// multiplier passes. Reset: synchronous active low.
// ----------------------------------------------------------------------------
`include "sliding_mode_position_controller_macros.svh"

module sliding_mode_position_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [smpc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [smpc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  smpc_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output smpc_pkg::out_t                 m_data
);

    smpc_pkg::cmd_t    cmd;
    smpc_pkg::status_t status;

    smpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    smpc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `SMPC_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken while busy")
    `SMPC_ASSERT_NXT(a_no_early_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid), "result raised too early")
    `SMPC_ASSERT_IMP(a_hold_zero, aclk, aresetn, m_valid && (m_data.motion == smpc_pkg::MOTION_HOLD), m_data.drive_duty == '0, "hold with nonzero duty")
    `SMPC_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, !m_valid || m_ready, "result overwritten")

endmodule
